@@ sv/can_frame_change_table_assert.svh @@
// Assertion macros used by the table RTL.
`ifndef CAN_FRAME_CHANGE_TABLE_ASSERT_SVH
`define CAN_FRAME_CHANGE_TABLE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CFCT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define CFCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/cfct_pkg.sv @@
package cfct_pkg;

  localparam int ID_W    = 29;
  localparam int LEN_W   = 4;
  localparam int DATA_W  = 64;
  localparam int STAMP_W = 32;
  localparam int COUNT_W = 32;
  localparam int SLOT_W  = 5;

  localparam logic [LEN_W-1:0] MAX_LEN = 4'd8;

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [2:0] {
    ST_NEW       = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_REFRESHED = 3'd2,
    ST_FULL      = 3'd3,
    ST_REMOVED   = 3'd4,
    ST_NOT_FOUND = 3'd5
  } status_t;

  // Contents of one table entry.
  typedef struct packed {
    logic [ID_W-1:0]    can_id;
    logic [LEN_W-1:0]   length;
    logic [DATA_W-1:0]  payload;
    logic [COUNT_W-1:0] count;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  // Allocation write broadcast to all cells.
  typedef struct packed {
    logic   en;
    entry_t entry;
  } alloc_t;

  // Search word walking down the cell chain.
  typedef struct packed {
    logic               active;
    logic               op;
    logic [ID_W-1:0]    can_id;
    logic [LEN_W-1:0]   len;
    logic [DATA_W-1:0]  data;
    logic [STAMP_W-1:0] stamp;
    logic               hit;
    logic               free_found;
    status_t            status;
    logic [COUNT_W-1:0] count;
    logic [LEN_W-1:0]   rlen;
    logic [DATA_W-1:0]  rpayload;
  } token_t;

  typedef struct packed {
    status_t            status;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] hit_count;
    logic [LEN_W-1:0]   stored_length;
    logic [DATA_W-1:0]  stored_payload;
  } result_t;

  // Ones over the bytes below len (len already clamped to 0..8).
  function automatic logic [DATA_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int j = 0; j < DATA_W / 8; j++) begin
      m[8*j +: 8] = (LEN_W'(j) < len) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

@@ sv/cfct_chan_if.sv @@
interface cfct_in_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [cfct_pkg::ID_W-1:0]    can_id;
  logic [cfct_pkg::LEN_W-1:0]   data_length;
  logic [cfct_pkg::DATA_W-1:0]  payload;
  logic [cfct_pkg::STAMP_W-1:0] receive_stamp;

  modport source (output valid, op, can_id, data_length, payload, receive_stamp,
                  input ready);
  modport sink (input valid, op, can_id, data_length, payload, receive_stamp,
                output ready);
endinterface

interface cfct_out_if;
  logic                         valid;
  logic                         ready;
  logic [2:0]                   status;
  logic [cfct_pkg::SLOT_W-1:0]  slot;
  logic [cfct_pkg::COUNT_W-1:0] hit_count;
  logic [cfct_pkg::LEN_W-1:0]   stored_length;
  logic [cfct_pkg::DATA_W-1:0]  stored_payload;

  modport source (output valid, status, slot, hit_count, stored_length, stored_payload,
                  input ready);
  modport sink (input valid, status, slot, hit_count, stored_length, stored_payload,
                output ready);
endinterface

@@ sv/can_frame_change_table.sv @@
// CAN frame change table. Keeps up to TABLE_ENTRIES frames keyed by identifier,
// one entry per cell in a chain of cells. A request word (record or remove) is
// taken when req.ready is high, then walks the chain one cell per clock: the
// first valid cell whose identifier matches updates or frees itself, and the
// first free cell is remembered. After the last cell the result is formed, a
// new entry is written into the remembered free cell if needed, and the result
// passes through a holding register to the rsp output register. One request is
// in the chain at a time: the next request is taken only once the result has
// moved from the holding register into the rsp output register. A result
// waiting on rsp does not hold off the next request; only a second finished
// result with the first still untaken does. Table full and not found return
// zero slot, count, length and payload. slot carries the low 5 bits of the
// entry index.
module can_frame_change_table #(
  parameter int TABLE_ENTRIES = 32
) (
  input  logic clk,
  input  logic rst,
  cfct_in_if.sink    req,
  cfct_out_if.source rsp
);

  `include "can_frame_change_table_assert.svh"

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  cfct_pkg::token_t tok    [0:TABLE_ENTRIES];
  logic [IW-1:0]    free_w [0:TABLE_ENTRIES];
  logic [IW-1:0]    slot_w [0:TABLE_ENTRIES];

  cfct_pkg::alloc_t  alloc;
  cfct_pkg::result_t res;
  cfct_pkg::result_t done_q;
  cfct_pkg::result_t out_q;
  cfct_pkg::token_t  tail;
  logic              done_valid;
  logic              out_valid;
  logic              busy;
  logic              accept;
  logic              move;
  logic [cfct_pkg::LEN_W-1:0]  len_clamp;
  logic [cfct_pkg::DATA_W-1:0] new_payload;

  assign req.ready = !busy;
  assign accept    = req.valid && !busy;
  assign len_clamp = (req.data_length > cfct_pkg::MAX_LEN) ? cfct_pkg::MAX_LEN
                                                          : req.data_length;

  // Head of the chain: the request enters cell 0 on the accepting edge.
  always_comb begin
    tok[0]            = '0;
    tok[0].active     = accept;
    tok[0].op         = req.op;
    tok[0].can_id     = req.can_id;
    tok[0].len        = len_clamp;
    tok[0].data       = req.payload;
    tok[0].stamp      = req.receive_stamp;
    tok[0].status     = cfct_pkg::ST_NOT_FOUND;
    free_w[0]         = '0;
    slot_w[0]         = '0;
  end

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    cfct_cell #(
      .IW         (IW),
      .CELL_INDEX (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .tok_in    (tok[i]),
      .free_in   (free_w[i]),
      .slot_in   (slot_w[i]),
      .alloc     (alloc),
      .alloc_idx (free_w[TABLE_ENTRIES]),
      .tok_out   (tok[i+1]),
      .free_out  (free_w[i+1]),
      .slot_out  (slot_w[i+1])
    );
  end

  assign tail        = tok[TABLE_ENTRIES];
  assign new_payload = tail.data & cfct_pkg::byte_mask(tail.len);

  // New entry goes into the lowest free cell once the whole chain missed.
  always_comb begin
    alloc.en           = tail.active && !tail.hit && (tail.op == cfct_pkg::OP_RECORD)
                         && tail.free_found;
    alloc.entry.can_id  = tail.can_id;
    alloc.entry.length  = tail.len;
    alloc.entry.payload = new_payload;
    alloc.entry.count   = cfct_pkg::COUNT_W'(1);
    alloc.entry.stamp   = tail.stamp;
  end

  // Result at the end of the chain.
  always_comb begin
    res = '0;
    if (tail.hit) begin
      res.status         = tail.status;
      res.slot           = cfct_pkg::SLOT_W'(slot_w[TABLE_ENTRIES]);
      res.hit_count      = tail.count;
      res.stored_length  = tail.rlen;
      res.stored_payload = tail.rpayload;
    end else if (tail.op == cfct_pkg::OP_REMOVE) begin
      res.status = cfct_pkg::ST_NOT_FOUND;
    end else if (tail.free_found) begin
      res.status         = cfct_pkg::ST_NEW;
      res.slot           = cfct_pkg::SLOT_W'(free_w[TABLE_ENTRIES]);
      res.hit_count      = cfct_pkg::COUNT_W'(1);
      res.stored_length  = tail.len;
      res.stored_payload = new_payload;
    end else begin
      res.status = cfct_pkg::ST_FULL;
    end
  end

  // done -> out whenever the output register is empty or being drained
  assign move = done_valid && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (tail.active) begin
      done_q <= res;
    end
    if (move) begin
      out_q <= done_q;
    end
    if (rst) begin
      busy       <= 1'b0;
      done_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (move) begin
        busy <= 1'b0;
      end
      if (tail.active) begin
        done_valid <= 1'b1;
      end else if (move) begin
        done_valid <= 1'b0;
      end
      if (move) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_q.status;
  assign rsp.slot           = out_q.slot;
  assign rsp.hit_count      = out_q.hit_count;
  assign rsp.stored_length  = out_q.stored_length;
  assign rsp.stored_payload = out_q.stored_payload;

  // Only one request in flight: it reaches the chain end with the holding slot free.
  `CFCT_ASSERT_NOW(a_tail_single, tail.active, busy && !done_valid, "tail word overlaps held result")
  // A held result lands in the output register and frees the table.
  `CFCT_ASSERT_NEXT(a_move, move, out_valid && !done_valid && !busy, "held result not forwarded")
  // A new entry is only reported for a record that missed and found a free cell.
  `CFCT_ASSERT_NOW(a_new_alloc, tail.active && res.status == cfct_pkg::ST_NEW, alloc.en, "new without allocation")

endmodule

@@ sv/cfct_cell.sv @@
module cfct_cell #(
  parameter int IW         = 5,
  parameter int CELL_INDEX = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  cfct_pkg::token_t    tok_in,
  input  logic [IW-1:0]       free_in,
  input  logic [IW-1:0]       slot_in,
  input  cfct_pkg::alloc_t    alloc,
  input  logic [IW-1:0]       alloc_idx,
  output cfct_pkg::token_t    tok_out,
  output logic [IW-1:0]       free_out,
  output logic [IW-1:0]       slot_out
);

  localparam logic [IW-1:0] MY_IDX = IW'(CELL_INDEX);

  logic                      ent_valid;
  logic                      ent_valid_next;
  cfct_pkg::entry_t          ent;
  cfct_pkg::entry_t          ent_next;
  cfct_pkg::token_t          tok_next;
  logic [IW-1:0]             free_next;
  logic [IW-1:0]             slot_next;
  logic [cfct_pkg::DATA_W-1:0] mask;
  logic                      changed;
  logic                      match;

  assign match = tok_in.active && ent_valid && !tok_in.hit && (ent.can_id == tok_in.can_id);
  assign mask  = cfct_pkg::byte_mask(tok_in.len);
  assign changed = |((ent.payload ^ tok_in.data) & mask);

  always_comb begin
    tok_next       = tok_in;
    free_next      = free_in;
    slot_next      = slot_in;
    ent_valid_next = ent_valid;
    ent_next       = ent;

    // first free entry seen on the way down
    if (tok_in.active && !ent_valid && !tok_in.free_found) begin
      tok_next.free_found = 1'b1;
      free_next           = MY_IDX;
    end

    if (match) begin
      tok_next.hit = 1'b1;
      slot_next    = MY_IDX;
      if (tok_in.op == cfct_pkg::OP_REMOVE) begin
        ent_valid_next     = 1'b0;
        tok_next.status    = cfct_pkg::ST_REMOVED;
        tok_next.count     = ent.count;
        tok_next.rlen      = ent.length;
        tok_next.rpayload  = ent.payload;
      end else begin
        ent_next.payload = (ent.payload & ~mask) | (tok_in.data & mask);
        ent_next.length  = tok_in.len;
        ent_next.stamp   = tok_in.stamp;
        if (ent.count != '1) begin
          ent_next.count = ent.count + 1'b1;
        end
        tok_next.status   = changed ? cfct_pkg::ST_UPDATED : cfct_pkg::ST_REFRESHED;
        tok_next.count    = ent_next.count;
        tok_next.rlen     = ent_next.length;
        tok_next.rpayload = ent_next.payload;
      end
    end

    if (alloc.en && alloc_idx == MY_IDX) begin
      ent_valid_next = 1'b1;
      ent_next       = alloc.entry;
    end
  end

  always_ff @(posedge clk) begin
    ent      <= ent_next;
    free_out <= free_next;
    slot_out <= slot_next;
    if (rst) begin
      ent_valid <= 1'b0;
      tok_out   <= '0;
    end else begin
      ent_valid <= ent_valid_next;
      tok_out   <= tok_next;
    end
  end

endmodule
